@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/rcl_pkg.sv @@
// ---------------------------------------------------------------------------
// rcl_pkg
// Command and status codes of the ranked character list.
// ---------------------------------------------------------------------------
package rcl_pkg;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_DELETE,
        CMD_GET,
        CMD_PRINT
    } cmd_t;

    typedef enum logic [2:0] {
        ST_GET,
        ST_PRINT,
        ST_EMPTY,
        ST_INVALID,
        ST_FULL
    } status_t;

endpackage

@@ rtl/core/ranked_char_list_top.sv @@
// Output: a get, an error or the empty marker moves from S_IDLE to S_PDATA or S_RESP and is
// registered in the output registers; print loads its first element the same way, then one a
// cycle while m_tready holds. Commands: s_tready is high only in S_IDLE, so add and delete hold
// the input until all moves through the single read and single write port of the element memory
// are done, and get, errors and print until their last beat is loaded; output stalls add to these.
// Reset: aresetn clears state, length and both valid flags; the element memory is not cleared.
// ---------------------------------------------------------------------------
// ranked_char_list_top
// Ordered byte list addressed by one-based rank, held in a one-port-read,
// one-port-write synchronous memory; inserts and deletes shift entries
// through a read-then-write pipeline.
// ---------------------------------------------------------------------------
module ranked_char_list_top
    import rcl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rank, [15:8] item
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] value
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PDATA,
        S_RESP
    } state_t;

    state_t          state_reg;
    logic [LW-1:0]   len_reg;
    logic            is_ins_reg;
    logic [AW-1:0]   pos_reg;
    logic [7:0]      item_reg;
    logic [AW-1:0]   rd_addr_reg;
    logic [LW-1:0]   rd_left_reg;
    logic            mv_vld_reg;
    logic [AW-1:0]   mv_addr_reg;
    logic [7:0]      rdata_reg;
    logic [AW-1:0]   cnt_reg;
    logic [AW-1:0]   end_reg;
    status_t         dstat_reg;
    logic            m_tvalid_reg;
    logic [7:0]      m_value_reg;
    status_t         m_status_reg;
    logic            m_last_reg;

    logic [7:0]      mem [CAPACITY];

    cmd_t            in_cmd;
    logic [7:0]      in_rank;
    logic [7:0]      in_item;
    logic [7:0]      rank_m1;
    logic [AW-1:0]   pos;
    logic [LW-1:0]   len_m1;
    logic [8:0]      len9;
    logic [8:0]      rank9;
    logic            full;
    logic            add_bad;
    logic            rd_bad;
    logic            out_free;
    logic            m_load;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_rank  = s_tdata[7:0];
    assign in_item  = s_tdata[15:8];
    assign rank_m1  = in_rank - 8'd1;
    assign pos      = rank_m1[AW-1:0];
    assign len_m1   = len_reg - LW'(1);
    assign len9     = 9'(len_reg);
    assign rank9    = {1'b0, in_rank};
    assign full     = (len_reg == LW'(CAPACITY));
    assign add_bad  = (in_rank == 8'd0) || (rank9 > (len9 + 9'd1));
    assign rd_bad   = (in_rank == 8'd0) || (rank9 > len9);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_load   = out_free && ((state_reg == S_PDATA) || (state_reg == S_RESP));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = rd_addr_reg;
        mem_we    = 1'b0;
        mem_waddr = mv_addr_reg;
        mem_wdata = rdata_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && (in_cmd == CMD_GET) && !rd_bad) begin
                    mem_re    = 1'b1;
                    mem_raddr = pos;
                end
                if (s_tvalid && (in_cmd == CMD_PRINT) && (len_reg != '0)) begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                end
            end
            S_SHIFT: begin
                if (rd_left_reg != '0) begin
                    mem_re = 1'b1;
                end
                if (mv_vld_reg) begin
                    mem_we = 1'b1;
                end else if (rd_left_reg == '0) begin
                    mem_we    = is_ins_reg;
                    mem_waddr = pos_reg;
                    mem_wdata = item_reg;
                end
            end
            S_PDATA: begin
                if (out_free && (cnt_reg != end_reg)) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + AW'(1);
                end
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            mv_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_load || (m_tvalid_reg && !m_tready);
            mv_vld_reg   <= (state_reg == S_SHIFT) && (rd_left_reg != '0);
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        item_reg <= in_item;
                        pos_reg  <= pos;
                        case (in_cmd)
                            CMD_ADD: begin
                                if (full) begin
                                    dstat_reg <= ST_FULL;
                                    state_reg <= S_RESP;
                                end else if (add_bad) begin
                                    dstat_reg <= ST_INVALID;
                                    state_reg <= S_RESP;
                                end else begin
                                    is_ins_reg  <= 1'b1;
                                    rd_addr_reg <= len_m1[AW-1:0];
                                    rd_left_reg <= len_reg - LW'(rank_m1);
                                    state_reg   <= S_SHIFT;
                                end
                            end
                            CMD_DELETE: begin
                                if (rd_bad) begin
                                    dstat_reg <= ST_INVALID;
                                    state_reg <= S_RESP;
                                end else begin
                                    is_ins_reg  <= 1'b0;
                                    rd_addr_reg <= in_rank[AW-1:0];
                                    rd_left_reg <= len_reg - LW'(in_rank);
                                    state_reg   <= S_SHIFT;
                                end
                            end
                            CMD_GET: begin
                                if (rd_bad) begin
                                    dstat_reg <= ST_INVALID;
                                    state_reg <= S_RESP;
                                end else begin
                                    dstat_reg <= ST_GET;
                                    cnt_reg   <= pos;
                                    end_reg   <= pos;
                                    state_reg <= S_PDATA;
                                end
                            end
                            default: begin
                                if (len_reg == '0) begin
                                    dstat_reg <= ST_EMPTY;
                                    state_reg <= S_RESP;
                                end else begin
                                    dstat_reg <= ST_PRINT;
                                    cnt_reg   <= '0;
                                    end_reg   <= len_m1[AW-1:0];
                                    state_reg <= S_PDATA;
                                end
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (rd_left_reg != '0) begin
                        rd_left_reg <= rd_left_reg - LW'(1);
                        rd_addr_reg <= is_ins_reg ? rd_addr_reg - AW'(1) : rd_addr_reg + AW'(1);
                        mv_addr_reg <= is_ins_reg ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1);
                    end else if (!mv_vld_reg) begin
                        len_reg   <= is_ins_reg ? len_reg + LW'(1) : len_m1;
                        state_reg <= S_IDLE;
                    end
                end
                S_PDATA: begin
                    if (out_free) begin
                        m_status_reg <= dstat_reg;
                        m_value_reg  <= rdata_reg;
                        m_last_reg   <= (cnt_reg == end_reg);
                        if (cnt_reg == end_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg + AW'(1);
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_status_reg <= dstat_reg;
                        m_value_reg  <= 8'd0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/rcl_checker.sv @@
// ---------------------------------------------------------------------------
// rcl_port_checks
// Port-level checks on the result channel of the ranked character list.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcl_port_checks
    import rcl_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    logic [11:0] m_beat;
    logic        m_marker;

    assign m_beat   = {m_tlast, m_tuser, m_tdata};
    assign m_marker = (m_tuser == ST_EMPTY) || (m_tuser == ST_INVALID) || (m_tuser == ST_FULL);

    // hold a stalled result beat
    `ASSERT_NXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_beat))

    `ASSERT_IMP(a_status_range, aclk, aresetn, m_tvalid, m_tuser <= ST_FULL)

    // single-beat answers always close the command
    `ASSERT_IMP(a_single_last, aclk, aresetn, m_tvalid && (m_tuser != ST_PRINT), m_tlast)

    `ASSERT_IMP(a_marker_zero, aclk, aresetn, m_tvalid && m_marker, m_tdata == 8'd0)

endmodule

bind ranked_char_list_top rcl_port_checks u_rcl_checker (.*);
